FILE: rtl/core/nus_pkg.sv
package nus_pkg;

  // fixed field widths
  localparam int SCALE_W   = 4;
  localparam int DIM_W     = 13;
  localparam int DATA_W    = 32;
  localparam int INDEX_W   = 32;
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int DEF_MAX_SCALE   = 8;
  localparam int DEF_MAX_DIM     = 4096;
  localparam int DEF_QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [SCALE_W-1:0] RST_SCALE  = SCALE_W'(2);
  localparam logic               RST_MODE   = 1'b0;
  localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(64);

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_MODE   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  // input element
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              first;
  } elem_t;

  // one output copy
  typedef struct packed {
    logic [INDEX_W-1:0] out_index;
    logic [DATA_W-1:0]  out_value;
    logic               last;
  } copy_t;

  // configuration registers as seen by the front end
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               mode_1d;
    logic [DIM_W-1:0]   in_width;
    logic [DIM_W-1:0]   in_height;
  } cfg_t;

  // work for the back end: one replicated block
  typedef struct packed {
    logic [INDEX_W-1:0] base;
    logic [DATA_W-1:0]  value;
    logic [INDEX_W-1:0] wo;
    logic [SCALE_W-1:0] s_m1;
    logic [SCALE_W-1:0] rows_m1;
  } desc_t;

endpackage

FILE: rtl/core/nearest_upsample_scatter_unit.sv
// Elements pass the front end stage registers, the queue and the back end registers.
// Throughput: one copy per cycle from the back end output register when not stalled;
// an element yields scale*scale copies in 2D mode and scale in 1D (4 at reset values).
// Front end: a new element every cycle while the queue (4 deep by default) has room.
// Reset (rst, synchronous): registers to scale 2, 2D, 64 by 64; positions cleared.
module nearest_upsample_scatter_unit import nus_pkg::*; #(
  parameter int MAX_SCALE   = DEF_MAX_SCALE,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 elem_valid,
  output logic                 elem_stall,
  input  elem_t                elem,
  output logic                 copy_valid,
  input  logic                 copy_stall,
  output copy_t                copy
);

  cfg_t  cfg;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t push_desc;
  desc_t pop_desc;
  logic  back_active;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale     <= RST_SCALE;
      cfg.mode_1d   <= RST_MODE;
      cfg.in_width  <= RST_WIDTH;
      cfg.in_height <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE:  cfg.scale     <= cfg_data[SCALE_W-1:0];
        CFG_MODE:   cfg.mode_1d   <= cfg_data[0];
        CFG_WIDTH:  cfg.in_width  <= cfg_data;
        CFG_HEIGHT: cfg.in_height <= cfg_data;
        default: ;
      endcase
    end
  end

  nus_front #(
    .MAX_SCALE (MAX_SCALE),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem),
    .push       (q_push),
    .q_full     (q_full),
    .push_desc  (push_desc)
  );

  nus_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_desc  (pop_desc)
  );

  nus_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop_desc   (pop_desc),
    .pop        (q_pop),
    .active     (back_active),
    .copy_valid (copy_valid),
    .copy_stall (copy_stall),
    .copy       (copy)
  );

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) && !rst |-> !copy_valid)
    else $error("copy offered straight after reset");

  // queue cannot be both empty and full
  a_queue_level: assert property (@(posedge clk) disable iff (rst) !(q_empty && q_full))
    else $error("queue level inconsistent");

  // a copy that is not the last leaves its block still in progress
  a_block_open: assert property (@(posedge clk) disable iff (rst)
    copy_valid && !copy.last |-> back_active)
    else $error("block closed before its last copy");

endmodule

FILE: rtl/core/nus_front.sv
module nus_front import nus_pkg::*; #(
  parameter int MAX_SCALE = DEF_MAX_SCALE,
  parameter int MAX_DIM   = DEF_MAX_DIM
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  elem_valid,
  output logic  elem_stall,
  input  elem_t elem,
  output logic  push,
  input  logic  q_full,
  output desc_t push_desc
);

  localparam int CW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int RSW = CW + SCALE_W;
  localparam int OW  = DW + SCALE_W;
  localparam int PRW = RSW + OW;
  localparam int PSW = OW + OW;

  // position state
  logic [CW-1:0]      col_pos;
  logic [CW-1:0]      row_pos;
  logic [INDEX_W-1:0] plane_base;

  // accept-side decode
  logic [SCALE_W-1:0] s_c;
  logic [DW-1:0]      w_c;
  logic [DW-1:0]      h_c;
  logic [CW-1:0]      col_eff;
  logic [CW-1:0]      row_eff;
  logic [CW:0]        col_inc;
  logic [CW:0]        row_inc;
  logic [CW-1:0]      col_pos_next;
  logic [CW-1:0]      row_pos_next;
  logic               eop;
  logic               accept;

  // stage 1
  logic               v1;
  logic [DATA_W-1:0]  s1_value;
  logic               s1_first;
  logic               s1_eop;
  logic               s1_one_d;
  logic [RSW-1:0]     s1_row_s;
  logic [RSW-1:0]     s1_col_s;
  logic [OW-1:0]      s1_wo;
  logic [OW-1:0]      s1_hs;
  logic [SCALE_W-1:0] s1_s_m1;
  logic [SCALE_W-1:0] s1_rows_m1;

  // stage 2
  logic               v2;
  logic [DATA_W-1:0]  s2_value;
  logic               s2_first;
  logic               s2_eop;
  logic [INDEX_W-1:0] s2_row_off;
  logic [RSW-1:0]     s2_col_s;
  logic [INDEX_W-1:0] s2_pstep;
  logic [INDEX_W-1:0] s2_wo;
  logic [SCALE_W-1:0] s2_s_m1;
  logic [SCALE_W-1:0] s2_rows_m1;

  logic               rdy1;
  logic               rdy2;
  logic [INDEX_W-1:0] pb_eff;

  // clamp the configuration to its legal ranges
  always_comb begin
    if (cfg.scale == '0) begin
      s_c = SCALE_W'(1);
    end else if (32'(cfg.scale) > 32'(MAX_SCALE)) begin
      s_c = SCALE_W'(MAX_SCALE);
    end else begin
      s_c = cfg.scale;
    end
    if (cfg.in_width == '0) begin
      w_c = DW'(1);
    end else if (32'(cfg.in_width) > 32'(MAX_DIM)) begin
      w_c = DW'(MAX_DIM);
    end else begin
      w_c = DW'(cfg.in_width);
    end
    if (cfg.in_height == '0) begin
      h_c = DW'(1);
    end else if (32'(cfg.in_height) > 32'(MAX_DIM)) begin
      h_c = DW'(MAX_DIM);
    end else begin
      h_c = DW'(cfg.in_height);
    end
  end

  // position counters advance per accepted element
  always_comb begin
    col_eff      = elem.first ? '0 : col_pos;
    row_eff      = elem.first ? '0 : row_pos;
    col_inc      = {1'b0, col_eff} + (CW+1)'(1);
    row_inc      = {1'b0, row_eff} + (CW+1)'(1);
    col_pos_next = col_inc[CW-1:0];
    row_pos_next = row_eff;
    eop          = 1'b0;
    if (32'(col_inc) >= 32'(w_c)) begin
      col_pos_next = '0;
      if (cfg.mode_1d) begin
        row_pos_next = '0;
        eop          = 1'b1;
      end else if (32'(row_inc) >= 32'(h_c)) begin
        row_pos_next = '0;
        eop          = 1'b1;
      end else begin
        row_pos_next = row_inc[CW-1:0];
      end
    end
  end

  // pipeline handshake
  assign rdy2       = !v2 || !q_full;
  assign rdy1       = !v1 || rdy2;
  assign accept     = elem_valid && rdy1;
  assign elem_stall = !rdy1;
  assign push       = v2 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // stage 1: small products of position and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= elem_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value   <= elem.value;
      s1_first   <= elem.first;
      s1_eop     <= eop;
      s1_one_d   <= cfg.mode_1d;
      s1_row_s   <= RSW'(row_eff) * RSW'(s_c);
      s1_col_s   <= RSW'(col_eff) * RSW'(s_c);
      s1_wo      <= OW'(w_c) * OW'(s_c);
      s1_hs      <= OW'(h_c) * OW'(s_c);
      s1_s_m1    <= s_c - SCALE_W'(1);
      s1_rows_m1 <= cfg.mode_1d ? '0 : s_c - SCALE_W'(1);
    end
  end

  // stage 2: row offset and plane size
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_value   <= s1_value;
      s2_first   <= s1_first;
      s2_eop     <= s1_eop;
      s2_row_off <= s1_one_d ? '0 : INDEX_W'(PRW'(s1_row_s) * PRW'(s1_wo));
      s2_col_s   <= s1_col_s;
      s2_pstep   <= s1_one_d ? INDEX_W'(s1_wo) : INDEX_W'(PSW'(s1_hs) * PSW'(s1_wo));
      s2_wo      <= INDEX_W'(s1_wo);
      s2_s_m1    <= s1_s_m1;
      s2_rows_m1 <= s1_rows_m1;
    end
  end

  // block base index and plane advance on transfer into the queue
  assign pb_eff = s2_first ? '0 : plane_base;

  always_comb begin
    push_desc.base    = pb_eff + s2_row_off + INDEX_W'(s2_col_s);
    push_desc.value   = s2_value;
    push_desc.wo      = s2_wo;
    push_desc.s_m1    = s2_s_m1;
    push_desc.rows_m1 = s2_rows_m1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_base <= '0;
    end else if (push) begin
      plane_base <= s2_eop ? pb_eff + s2_pstep : pb_eff;
    end
  end

endmodule

FILE: rtl/core/nus_queue.sv
module nus_queue import nus_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output desc_t pop_desc
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  desc_t          slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [NW-1:0]  count;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_desc = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/nus_back.sv
module nus_back import nus_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  desc_t pop_desc,
  output logic  pop,
  output logic  active,
  output logic  copy_valid,
  input  logic  copy_stall,
  output copy_t copy
);

  logic [SCALE_W-1:0] dx;
  logic [SCALE_W-1:0] dy;
  logic [INDEX_W-1:0] idx;
  logic [INDEX_W-1:0] row_start;
  logic [DATA_W-1:0]  value;
  logic [INDEX_W-1:0] wo;
  logic [SCALE_W-1:0] s_m1;
  logic [SCALE_W-1:0] rows_m1;
  logic               can_load;
  logic               emit;
  logic               row_end;
  logic               last_copy;

  assign can_load  = !copy_valid || !copy_stall;
  assign emit      = active && can_load;
  assign row_end   = (dx == s_m1);
  assign last_copy = row_end && (dy == rows_m1);
  assign pop       = !q_empty && (!active || (emit && last_copy));

  // walk the block one copy per cycle while copy_stall does not hold the output
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (emit && last_copy) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dx        <= '0;
      dy        <= '0;
      idx       <= pop_desc.base;
      row_start <= pop_desc.base;
      value     <= pop_desc.value;
      wo        <= pop_desc.wo;
      s_m1      <= pop_desc.s_m1;
      rows_m1   <= pop_desc.rows_m1;
    end else if (emit) begin
      if (row_end) begin
        dx        <= '0;
        dy        <= dy + SCALE_W'(1);
        row_start <= row_start + wo;
        idx       <= row_start + wo;
      end else begin
        dx  <= dx + SCALE_W'(1);
        idx <= idx + INDEX_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_valid <= 1'b0;
    end else if (can_load) begin
      copy_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      copy.out_index <= idx;
      copy.out_value <= value;
      copy.last      <= last_copy;
    end
  end

endmodule
